// ===== rtl/core/lpht_pkg.sv =====
`default_nettype none

package lpht_pkg;

  localparam int KEY_W          = 31;
  localparam int SLOT_W         = 4;
  localparam int TABLE_SIZE_DEF = 16;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_SEARCH = 1'b1;

  typedef struct packed {
    logic             vld;
    logic             kind;
    logic [KEY_W-1:0] key;
  } tok_t;

  typedef struct packed {
    logic              done;
    logic              hit;
    logic              stored;
    logic [SLOT_W-1:0] slot;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/core/lpht_mod.sv =====
`default_nettype none

module lpht_mod #(
  parameter int TABLE_SIZE = lpht_pkg::TABLE_SIZE_DEF,
  localparam int IW = $clog2(TABLE_SIZE)
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start_i,
  input  wire logic [lpht_pkg::KEY_W-1:0] key_i,
  output logic                          done_o,
  output logic [IW-1:0]                 home_o
);
  import lpht_pkg::*;

  localparam int RW = KEY_W + 2;
  localparam int PW = KEY_W + RW;
  localparam int SH = KEY_W + IW;
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << SH) + 64'(TABLE_SIZE) - 64'd1) / 64'(TABLE_SIZE);
  localparam logic [RW-1:0] RECIP   = RECIP_FULL[RW-1:0];
  localparam logic [IW-1:0] SIZE_LO = IW'(TABLE_SIZE);

  logic [PW-1:0]   prod;
  logic [2*IW-1:0] back;
  logic [IW-1:0]   quot_r;
  logic [IW-1:0]   key_lo_r;
  logic [IW-1:0]   rem_r;
  logic            mul_r;
  logic            done_r;

  // The quotient comes from a multiplication with the rounded-up reciprocal of
  // TABLE_SIZE. Only the low bits of quotient and key are needed for the remainder.
  assign prod = {{RW{1'b0}}, key_i} * {{KEY_W{1'b0}}, RECIP};
  assign back = {{IW{1'b0}}, quot_r} * {{IW{1'b0}}, SIZE_LO};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      mul_r  <= start_i;
      done_r <= mul_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start_i) begin
      quot_r   <= prod[SH +: IW];
      key_lo_r <= key_i[IW-1:0];
    end
    if (mul_r) begin
      rem_r <= key_lo_r - back[IW-1:0];
    end
  end

  assign done_o = done_r;
  assign home_o = rem_r;

endmodule

`default_nettype wire

// ===== rtl/core/lpht_cell.sv =====
`default_nettype none

module lpht_cell #(
  parameter int IDX = 0
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire lpht_pkg::tok_t prev_i,
  input  wire logic          inject_i,
  input  wire lpht_pkg::tok_t inj_tok_i,
  input  wire logic          kill_i,
  output lpht_pkg::tok_t     pass_o,
  output lpht_pkg::res_t     res_o
);
  import lpht_pkg::*;

  localparam logic [SLOT_W-1:0] SLOT_ID = SLOT_W'(IDX);

  tok_t             tok_r;
  tok_t             tok_nxt;
  logic [KEY_W-1:0] key_r;
  logic             valid_r;
  logic             done;
  logic             hit;
  logic             stored;

  assign hit    = tok_r.vld && valid_r && (tok_r.kind == KIND_SEARCH) && (tok_r.key == key_r);
  assign stored = tok_r.vld && !valid_r && (tok_r.kind == KIND_INSERT);
  assign done   = tok_r.vld && (!valid_r || hit);

  always_comb begin
    if (inject_i) begin
      tok_nxt = inj_tok_i;
    end else begin
      tok_nxt     = prev_i;
      tok_nxt.vld = prev_i.vld && !kill_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.vld <= 1'b0;
      valid_r   <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
      if (stored) begin
        valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stored) begin
      key_r <= tok_r.key;
    end
  end

  always_comb begin
    pass_o     = tok_r;
    pass_o.vld = tok_r.vld && !done;
    res_o.done   = done;
    res_o.hit    = hit;
    res_o.stored = stored;
    res_o.slot   = (hit || stored) ? SLOT_ID : '0;
  end

endmodule

`default_nettype wire

// ===== rtl/core/linear_probing_hash_table.sv =====
`default_nettype none

// Open-addressing hash table with linear probing over a ring of TABLE_SIZE slot
// cells. Each word is an insert or a search of a 31-bit key; every word gives
// exactly one result word. The home slot (key modulo TABLE_SIZE) comes from a
// multiplication with the reciprocal of TABLE_SIZE; the quotient is registered
// first and the remainder after it. A probe token then enters the home cell and
// moves one cell per cycle around the ring, so the walk visits at most
// TABLE_SIZE cells. An insert into a full table stores nothing and reports
// full_res. The result then goes to the output register, where a finished result
// waits until the previous one has drained, and the next word can be taken in the
// cycle after the result is written. The block takes one word at a time. The
// table is empty after reset. A new word is taken while the previous result
// still waits at the output.
module linear_probing_hash_table #(
  parameter int TABLE_SIZE = lpht_pkg::TABLE_SIZE_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          in_kind,
  input  wire logic [lpht_pkg::KEY_W-1:0]    in_key,
  input  wire logic                          in_batch_end,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_hit,
  output logic                               out_stored,
  output logic                               out_full_res,
  output logic [lpht_pkg::SLOT_W-1:0]        out_slot,
  output logic                               out_batch_done
);
  import lpht_pkg::*;

  localparam int IW = $clog2(TABLE_SIZE);
  localparam logic [IW-1:0] STEP_LAST = IW'(TABLE_SIZE - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HASH,
    ST_PROBE,
    ST_DRAIN
  } state_t;

  state_t           state_r;
  logic             kind_r;
  logic [KEY_W-1:0] key_r;
  logic             batch_r;
  logic [IW-1:0]    step_r;
  res_t             res_r;
  logic             full_r;

  logic              out_valid_r;
  logic              out_hit_r;
  logic              out_stored_r;
  logic              out_full_r;
  logic [SLOT_W-1:0] out_slot_r;
  logic              out_batch_r;

  logic          hash_start;
  logic          hash_done;
  logic [IW-1:0] home;
  logic          inj_en;
  logic          kill;
  tok_t          inj_tok;
  res_t          sum;

  tok_t                  pass   [TABLE_SIZE];
  res_t                  cres   [TABLE_SIZE];
  logic [TABLE_SIZE-1:0] done_vec;
  logic [TABLE_SIZE-1:0] tok_vec;

  assign in_stall   = (state_r != ST_IDLE);
  assign hash_start = (state_r == ST_IDLE) && in_valid;
  assign inj_en     = (state_r == ST_HASH) && hash_done;
  assign kill       = (state_r == ST_PROBE) && !sum.done && (step_r == STEP_LAST);

  always_comb begin
    inj_tok.vld  = 1'b1;
    inj_tok.kind = kind_r;
    inj_tok.key  = key_r;
  end

  lpht_mod #(
    .TABLE_SIZE(TABLE_SIZE)
  ) u_mod (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (hash_start),
    .key_i   (in_key),
    .done_o  (hash_done),
    .home_o  (home)
  );

  for (genvar i = 0; i < TABLE_SIZE; i++) begin : g_cell
    localparam int PREV = (i + TABLE_SIZE - 1) % TABLE_SIZE;

    lpht_cell #(
      .IDX(i)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .prev_i    (pass[PREV]),
      .inject_i  (inj_en && (home == IW'(i))),
      .inj_tok_i (inj_tok),
      .kill_i    (kill),
      .pass_o    (pass[i]),
      .res_o     (cres[i])
    );

    assign done_vec[i] = cres[i].done;
    assign tok_vec[i]  = pass[i].vld || cres[i].done;
  end

  // Only one token is ever in the ring, so the cell results merge by OR.
  always_comb begin
    sum = '0;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      sum = sum | cres[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && (state_r != ST_DRAIN)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            kind_r  <= in_kind;
            key_r   <= in_key;
            batch_r <= in_batch_end;
            state_r <= ST_HASH;
          end
        end
        ST_HASH: begin
          if (hash_done) begin
            step_r  <= '0;
            state_r <= ST_PROBE;
          end
        end
        ST_PROBE: begin
          if (sum.done) begin
            res_r   <= sum;
            full_r  <= 1'b0;
            state_r <= ST_DRAIN;
          end else if (step_r == STEP_LAST) begin
            res_r   <= '0;
            full_r  <= (kind_r == KIND_INSERT);
            state_r <= ST_DRAIN;
          end else begin
            step_r <= step_r + 1'b1;
          end
        end
        ST_DRAIN: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r  <= 1'b1;
            out_hit_r    <= res_r.hit;
            out_stored_r <= res_r.stored;
            out_full_r   <= full_r;
            out_slot_r   <= res_r.slot;
            out_batch_r  <= batch_r;
            state_r      <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hit        = out_hit_r;
  assign out_stored     = out_stored_r;
  assign out_full_res   = out_full_r;
  assign out_slot       = out_slot_r;
  assign out_batch_done = out_batch_r;

`ifndef SYNTHESIS
  a_one_done : assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(done_vec))
    else $error("more than one cell finished a probe in the same cycle");

  a_one_token : assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok_vec))
    else $error("more than one probe token in the ring");

  a_idle_ring : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_PROBE) |-> (tok_vec == '0))
    else $error("probe token in the ring outside the probe phase");

  a_full_word : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_full_r) |-> (!out_hit_r && !out_stored_r && (out_slot_r == '0)))
    else $error("full result word carries a hit, a store or a slot");
`endif

endmodule

`default_nettype wire
